FILE: sv/matrix_vector_multiply_top_assert.svh
// assertion macros for the matrix-vector multiply rtl
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MVM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mvm_pkg.sv
// types, constants and helpers shared by the matrix-vector multiply blocks
`default_nettype none

package mvm_pkg;

  localparam int IDX_W      = 8;
  localparam int VAL_W      = 16;
  localparam int ROW_W      = 4;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int QSHIFT     = 8;
  localparam int WDEPTH     = 256;
  localparam int WADDR_W    = 8;
  localparam int MAXRES     = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int SAT_HI     = 32767;
  localparam int SAT_LO     = -32768;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_VECTOR = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic                    store;
    logic                    start;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // arithmetic shift back to q8.8, then clamp to 16 bits
  function automatic logic signed [VAL_W-1:0] sat_q88(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> QSHIFT;
    if (sh > ACC_W'(SAT_HI)) begin
      sat_q88 = VAL_W'(SAT_HI);
    end else if (sh < ACC_W'(SAT_LO)) begin
      sat_q88 = VAL_W'(SAT_LO);
    end else begin
      sat_q88 = VAL_W'(sh);
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/matrix_vector_multiply_top.sv
// top level of the matrix-vector multiply engine
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid / in_stall   | operation, index, value, start_req
//   out     | result    | out_valid / out_stall | row, product, last
//
// weight and vector writes leave the queue one per cycle while idle and take effect in that cycle
// a start request runs min(ROWS,16)*COLS products on the single shared mac, one product a
// cycle unless the pipeline is frozen; the start is first taken off the queue, then each
// product passes the store read, multiply, accumulate and result registers
// the four-entry queue keeps taking requests during a run, then in_stall rises
// out_stall on a waiting result freezes the whole mac pipeline; reset clears control and acc_r, stores stay unknown
`default_nettype none

module matrix_vector_multiply_top #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_operation,
  input  wire logic [mvm_pkg::IDX_W-1:0]         in_index,
  input  wire logic signed [mvm_pkg::VAL_W-1:0]  in_value,
  input  wire logic                              in_start_req,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mvm_pkg::ROW_W-1:0]              out_row,
  output logic signed [mvm_pkg::VAL_W-1:0]       out_product,
  output logic                                   out_last
);
  import mvm_pkg::*;

  logic fifo_full;
  logic fifo_push;
  logic fifo_pop;
  logic fifo_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  mvm_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_index    (in_index),
    .in_value    (in_value),
    .in_start_req(in_start_req),
    .fifo_full   (fifo_full),
    .fifo_push   (fifo_push),
    .fifo_cmd    (push_cmd)
  );

  mvm_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_data(push_cmd),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_data (pop_cmd),
    .empty    (fifo_empty)
  );

  mvm_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_data  (pop_cmd),
    .fifo_pop   (fifo_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_product(out_product),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

FILE: sv/mvm_front.sv
// front end: classifies input requests into queue commands
`default_nettype none

module mvm_front #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_operation,
  input  wire logic [mvm_pkg::IDX_W-1:0]       in_index,
  input  wire logic signed [mvm_pkg::VAL_W-1:0] in_value,
  input  wire logic                            in_start_req,
  input  wire logic                            fifo_full,
  output logic                                 fifo_push,
  output mvm_pkg::cmd_t                        fifo_cmd
);
  import mvm_pkg::*;

  logic keep;
  logic weight_ok;
  logic vector_ok;

  assign weight_ok = 32'(in_index) < ROWS * COLS;
  assign vector_ok = 32'(in_index) < COLS;

  always_comb begin
    fifo_cmd.idx   = in_index;
    fifo_cmd.value = in_value;
    unique case (op_t'(in_operation))
      OP_WEIGHT: begin
        fifo_cmd.op    = OP_WEIGHT;
        fifo_cmd.store = weight_ok;
        fifo_cmd.start = 1'b0;
        keep           = weight_ok;
      end
      OP_VECTOR: begin
        // an out-of-range element with start still runs the multiply
        fifo_cmd.op    = OP_VECTOR;
        fifo_cmd.store = vector_ok;
        fifo_cmd.start = in_start_req;
        keep           = vector_ok | in_start_req;
      end
      default: begin
        fifo_cmd.op    = OP_WEIGHT;
        fifo_cmd.store = 1'b0;
        fifo_cmd.start = 1'b0;
        keep           = 1'b0;
      end
    endcase
  end

  // dropped requests are still taken, they just never reach the queue
  assign in_stall  = fifo_full;
  assign fifo_push = in_valid & ~fifo_full & keep;

endmodule

`default_nettype wire

FILE: sv/mvm_cmd_fifo.sv
// short command queue between the front end and the mac engine
`default_nettype none

module mvm_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mvm_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output mvm_pkg::cmd_t      pop_data,
  output logic               empty
);
  import mvm_pkg::*;

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PW:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = count_r == (FIFO_PW + 1)'(FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mvm_back.sv
// back end: weight and vector stores, shared mac pipeline, result register
`default_nettype none
`include "matrix_vector_multiply_top_assert.svh"

module mvm_back #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             fifo_empty,
  input  wire mvm_pkg::cmd_t                    fifo_data,
  output logic                                  fifo_pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [mvm_pkg::ROW_W-1:0]             out_row,
  output logic signed [mvm_pkg::VAL_W-1:0]      out_product,
  output logic                                  out_last
);
  import mvm_pkg::*;

  localparam int NRES = (ROWS < MAXRES) ? ROWS : MAXRES;
  localparam int NTOT = NRES * COLS;
  localparam int FW   = (NTOT > 1) ? $clog2(NTOT) : 1;
  localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;

  logic signed [VAL_W-1:0] wmem [WDEPTH];
  logic signed [VAL_W-1:0] vmem [COLS];

  state_t           state_r, state_nxt;
  logic [FW-1:0]    fi_r, fi_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             issue;
  logic             adv;
  logic             last_col;

  // stage 1: store reads
  logic                    s1_v_r;
  logic signed [VAL_W-1:0] w_q, v_q;
  logic                    s1_oob_r, s1_first_r, s1_lastcol_r, s1_lastrow_r;
  logic [ROW_W-1:0]        s1_row_r;
  // stage 2: product
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_first_r, s2_lastcol_r, s2_lastrow_r;
  logic [ROW_W-1:0]         s2_row_r;
  // stage 3: accumulator holds a finished row sum
  logic                    s3_v_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    s3_lastrow_r;
  logic [ROW_W-1:0]        s3_row_r;
  // result register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_product_r;
  logic [ROW_W-1:0]        out_row_r;
  logic                    out_last_r;

  // whole pipeline freezes while a result waits
  assign adv      = ~out_valid_r | ~out_stall;
  assign last_col = col_r == CW'(COLS - 1);

  always_comb begin
    state_nxt = state_r;
    fi_nxt    = fi_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    fifo_pop  = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop = 1'b1;
          if (fifo_data.start) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (adv) begin
          issue = 1'b1;
          if (fi_r == FW'(NTOT - 1)) begin
            state_nxt = ST_IDLE;
            fi_nxt    = '0;
            col_nxt   = '0;
            row_nxt   = '0;
          end else begin
            fi_nxt = fi_r + 1'b1;
            if (last_col) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fi_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      fi_r    <= fi_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (adv) begin
        s1_v_r      <= issue;
        s2_v_r      <= s1_v_r;
        s3_v_r      <= s2_v_r & s2_lastcol_r;
        out_valid_r <= s3_v_r;
        if (s2_v_r) begin
          acc_r <= s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
        end
      end
    end
  end

  // store writes come from the queue, reads from the mac sequencer
  always_ff @(posedge clk) begin
    if (fifo_pop && fifo_data.store && fifo_data.op == OP_WEIGHT) begin
      wmem[fifo_data.idx] <= fifo_data.value;
    end
    if (adv) begin
      w_q <= wmem[WADDR_W'(fi_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop && fifo_data.store && fifo_data.op == OP_VECTOR) begin
      vmem[fifo_data.idx[CW-1:0]] <= fifo_data.value;
    end
    if (adv) begin
      v_q <= vmem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_oob_r      <= 32'(fi_r) >= WDEPTH;
      s1_first_r    <= col_r == '0;
      s1_lastcol_r  <= last_col;
      s1_row_r      <= row_r;
      s1_lastrow_r  <= row_r == ROW_W'(NRES - 1);
      // flat indices past the weight store count as zero weights
      prod_r        <= s1_oob_r ? PROD_W'(0) : w_q * v_q;
      s2_first_r    <= s1_first_r;
      s2_lastcol_r  <= s1_lastcol_r;
      s2_row_r      <= s1_row_r;
      s2_lastrow_r  <= s1_lastrow_r;
      s3_row_r      <= s2_row_r;
      s3_lastrow_r  <= s2_lastrow_r;
      out_product_r <= sat_q88(acc_r);
      out_row_r     <= s3_row_r;
      out_last_r    <= s3_lastrow_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;
  assign out_row     = out_row_r;
  assign out_last    = out_last_r;

  `MVM_ASSERT_IMPL(a_run_in_range, state_r == ST_RUN, 32'(fi_r) < NTOT, "mac index past end")
  `MVM_ASSERT_NEXT(a_row_to_out, adv && s3_v_r, out_valid_r, "finished row not presented")
  `MVM_ASSERT_NEXT(a_acc_frozen, !adv, $stable(acc_r), "accumulator moved while stalled")
  `MVM_ASSERT_IMPL(a_last_row, out_valid_r && out_last_r, out_row_r == ROW_W'(NRES - 1), "bad last")

endmodule

`default_nettype wire

FILE: tb/matrix_vector_multiply_top_tb.sv
// self-checking testbench for the matrix-vector multiply engine, with a predictor and bursty traffic
`timescale 1ns / 100ps

module matrix_vector_multiply_top_tb;
  import mvm_pkg::*;

  localparam int ROWS       = 16;
  localparam int COLS       = 16;
  localparam int NROWS_OUT  = (ROWS < MAXRES) ? ROWS : MAXRES;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 1500;
  localparam int HOLD_AT    = 450;
  localparam int RAND_ITEMS = 220;

  typedef struct {
    op_t                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    start;
    logic                    wait_idle;
  } mvm_req_t;

  typedef struct {
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] product;
    logic                    last;
  } row_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [IDX_W-1:0] in_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic in_start_req = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROW_W-1:0] out_row;
  logic signed [VAL_W-1:0] out_product;
  logic out_last;

  mvm_req_t    pending_reqs[$];
  row_result_t row_results_due[$];

  logic signed [VAL_W-1:0] weight_mem [0:WDEPTH-1];
  logic signed [VAL_W-1:0] vector_mem [0:COLS-1];

  int mismatches = 0;
  int req_accepted = 0;
  int idle_cycles = 0;

  matrix_vector_multiply_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_index    (in_index),
    .in_value    (in_value),
    .in_start_req(in_start_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_product (out_product),
    .out_last    (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = 16'sh7fff;
      1: pick_value = 16'sh8000;
      2: pick_value = VAL_W'($signed($urandom_range(0, 1024)) - 512);
      default: pick_value = VAL_W'($urandom);
    endcase
  endfunction

  task automatic push_req(input op_t op, input int idx, input logic signed [VAL_W-1:0] value,
                          input logic start, input logic wait_idle);
    mvm_req_t req;
    req.op        = op;
    req.idx       = IDX_W'(idx);
    req.value     = value;
    req.start     = start;
    req.wait_idle = wait_idle;
    pending_reqs.push_back(req);
  endtask

  // store update and, on a start, the row dot products the engine must produce
  task automatic apply_gemv_request(input op_t op, input logic [IDX_W-1:0] idx,
                                    input logic signed [VAL_W-1:0] value, input logic start);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    logic signed [VAL_W-1:0] w;
    row_result_t res;
    int fi;
    if (op == OP_WEIGHT) begin
      if (int'(idx) < ROWS * COLS && int'(idx) < WDEPTH) weight_mem[idx] = value;
    end else begin
      if (int'(idx) < COLS) vector_mem[idx] = value;
      if (start) begin
        for (int r = 0; r < NROWS_OUT; r++) begin
          acc = '0;
          for (int j = 0; j < COLS; j++) begin
            fi = r * COLS + j;
            w = (fi < WDEPTH) ? weight_mem[fi] : '0;
            acc = acc + w * vector_mem[j];
          end
          // arithmetic shift rounds towards minus infinity
          shifted = acc >>> QSHIFT;
          if (shifted > 32767) res.product = 16'sh7fff;
          else if (shifted < -32768) res.product = 16'sh8000;
          else res.product = shifted[VAL_W-1:0];
          res.row  = ROW_W'(r);
          res.last = (r == NROWS_OUT - 1);
          row_results_due.push_back(res);
        end
      end
    end
  endtask

  // driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    mvm_req_t req;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_operation <= 1'b0;
      in_index     <= '0;
      in_value     <= '0;
      in_start_req <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].wait_idle && row_results_due.size() != 0)) begin
        req = pending_reqs.pop_front();
        in_valid     <= 1'b1;
        in_operation <= req.op;
        in_index     <= req.idx;
        in_value     <= req.value;
        in_start_req <= req.start;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the engine up
  int cycle_no = 0;
  int stall_mode = 0;
  int hold_left = 0;
  logic long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      cycle_no = cycle_no + 1;
      if (cycle_no % 256 == 0) stall_mode = $urandom_range(0, 3);
      if (!long_hold_done && req_accepted >= HOLD_AT) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cycle_no % 7) < 3);
        endcase
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results, watchdog
  always @(posedge clk) begin
    row_result_t due;
    logic progress;
    progress = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        progress = 1'b1;
        req_accepted = req_accepted + 1;
        apply_gemv_request(op_t'(in_operation), in_index, in_value, in_start_req);
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (row_results_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches < 100)
            $display("%0t unexpected result: expected none, actual row %0d product %0d last %0b",
                     $time, out_row, out_product, out_last);
        end else begin
          due = row_results_due.pop_front();
          if (out_row !== due.row) begin
            mismatches = mismatches + 1;
            if (mismatches < 100)
              $display("%0t row mismatch: expected %0d actual %0d", $time, due.row, out_row);
          end
          if (out_product !== due.product) begin
            mismatches = mismatches + 1;
            if (mismatches < 100)
              $display("%0t product mismatch on row %0d: expected %0d actual %0d",
                       $time, due.row, due.product, out_product);
          end
          if (out_last !== due.last) begin
            mismatches = mismatches + 1;
            if (mismatches < 100)
              $display("%0t last mismatch on row %0d: expected %0b actual %0b",
                       $time, due.row, due.last, out_last);
          end
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    logic signed [VAL_W-1:0] v;
    // fill every weight and vector entry before the first start
    for (int i = 0; i < WDEPTH; i++) begin
      case (i / COLS)
        0: v = 16'sh7fff;
        1: v = 16'sh8000;
        2: v = (i % 2) ? 16'sh7fff : 16'sh8000;
        3: v = -16'sd1;
        default: v = pick_value();
      endcase
      push_req(OP_WEIGHT, i, v, 1'b0, 1'b0);
    end
    for (int j = 0; j < COLS; j++) push_req(OP_VECTOR, j, 16'sh7fff, j == COLS - 1, 1'b0);

    // start flag on a weight write does nothing
    push_req(OP_WEIGHT, 255, 16'sh8000, 1'b1, 1'b0);
    // vector index past the end stores nothing, but a start still runs
    push_req(OP_VECTOR, COLS, 16'sd1234, 1'b0, 1'b0);
    push_req(OP_VECTOR, 255, 16'sd0, 1'b1, 1'b0);
    // single lsb in the vector: negative sums round down
    for (int j = 1; j < COLS; j++) push_req(OP_VECTOR, j, 16'sd0, 1'b0, 1'b0);
    push_req(OP_VECTOR, 0, 16'sd1, 1'b1, 1'b0);
    push_req(OP_VECTOR, 0, 16'sh8000, 1'b1, 1'b0);
    push_req(OP_WEIGHT, 0, 16'sd0, 1'b0, 1'b0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (n == 100) begin
        // a start, one write, then a write that waits for every result
        push_req(OP_VECTOR, $urandom_range(0, COLS - 1), pick_value(), 1'b1, 1'b0);
        push_req(OP_WEIGHT, $urandom_range(0, 255), pick_value(), 1'b0, 1'b0);
        push_req(OP_WEIGHT, $urandom_range(0, 255), pick_value(), 1'b0, 1'b1);
      end else if (r < 60) begin
        push_req(OP_WEIGHT, $urandom_range(0, 255), pick_value(), $urandom_range(0, 7) == 0,
                 1'b0);
      end else if (r < 85) begin
        push_req(OP_VECTOR, $urandom_range(0, COLS - 1), pick_value(), 1'b0, 1'b0);
      end else if (r < 90) begin
        push_req(OP_VECTOR, $urandom_range(COLS, 255), pick_value(), $urandom_range(0, 1),
                 1'b0);
      end else begin
        push_req(OP_VECTOR, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, COLS - 1),
                 pick_value(), 1'b1, 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (row_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && row_results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
